// ===== src/cvbe_pkg.sv =====
package cvbe_pkg;

	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int CNT_W = 16;
	localparam int SUM_W = 32;
	localparam int ACC_W = 48;
	localparam int HALF_W = ACC_W / 2;
	localparam int MUL_W = SUM_W + 1;
	localparam int WIDE_W = 64;
	localparam int BETA_W = 32;
	localparam int FRAC_W = 16;

	localparam logic [CNT_W-1:0] SAMPLE_COUNT_RST = 16'd1024;

	localparam logic [BETA_W-1:0] BETA_POS_LIMIT = 32'h7fff_ffff;
	localparam logic [BETA_W-1:0] BETA_NEG_LIMIT = 32'h8000_0000;

	typedef struct packed {
		logic [BETA_W-1:0] beta;
		logic              sat;
	} div_res_t;

endpackage

// ===== src/cvbe_mul.sv =====
module cvbe_mul (
	input  logic                                    clk,
	input  logic signed [cvbe_pkg::MUL_W-1:0]       a,
	input  logic signed [cvbe_pkg::MUL_W-1:0]       b,
	output logic        [cvbe_pkg::WIDE_W-1:0]      prod_q
);

	logic signed [2*cvbe_pkg::MUL_W-1:0] prod;

	assign prod = a * b;

	always_ff @(posedge clk) begin
		prod_q <= prod[cvbe_pkg::WIDE_W-1:0];
	end

endmodule

// ===== src/cvbe_div.sv =====
module cvbe_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [cvbe_pkg::WIDE_W-1:0]       num,
	input  logic [cvbe_pkg::WIDE_W-1:0]       den,
	output logic                              done,
	output cvbe_pkg::div_res_t                res
);

	localparam int W = cvbe_pkg::WIDE_W;
	localparam int QW = cvbe_pkg::BETA_W;
	localparam int FW = cvbe_pkg::FRAC_W;
	localparam int CW = $clog2(QW);
	localparam logic [CW-1:0] LAST_BIT = CW'(QW - 1);

	typedef enum logic [3:0] {
		D_IDLE = 4'b0001,
		D_CHK  = 4'b0010,
		D_ITER = 4'b0100,
		D_FIN  = 4'b1000
	} dstate_t;

	dstate_t state_q;
	logic [CW-1:0] cnt_q;
	logic done_q;

	logic [W-1:0] n_q;
	logic [W-1:0] d_q;
	logic neg_q;
	logic [W-1:0] rem_q;
	logic [QW-1:0] low_q;
	logic [QW-1:0] quo_q;
	cvbe_pkg::div_res_t res_q;

	logic [W:0] trial;
	logic [W:0] diff;
	logic qbit;
	logic [QW-1:0] limit;
	logic [QW-1:0] qclamp;
	logic ovf;

	assign trial = {rem_q, low_q[QW-1]};
	assign diff = trial - {1'b0, d_q};
	assign qbit = ~diff[W];
	assign ovf = {{FW{1'b0}}, n_q} >= {d_q, {FW{1'b0}}};
	assign limit = neg_q ? cvbe_pkg::BETA_NEG_LIMIT : cvbe_pkg::BETA_POS_LIMIT;
	assign qclamp = (quo_q > limit) ? limit : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				D_IDLE: begin
					if (start) begin
						state_q <= D_CHK;
					end
				end
				D_CHK: begin
					cnt_q <= '0;
					state_q <= ovf ? D_FIN : D_ITER;
				end
				D_ITER: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_BIT) begin
						state_q <= D_FIN;
					end
				end
				D_FIN: begin
					done_q <= 1'b1;
					state_q <= D_IDLE;
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			D_IDLE: begin
				if (start) begin
					n_q <= num[W-1] ? (W'(0) - num) : num;
					d_q <= den[W-1] ? (W'(0) - den) : den;
					neg_q <= num[W-1] ^ den[W-1];
				end
			end
			D_CHK: begin
				if (ovf) begin
					// force above the limit so the final step clamps
					quo_q <= limit + 1'b1;
				end else begin
					rem_q <= {{FW{1'b0}}, n_q[W-1:FW]};
					low_q <= {n_q[FW-1:0], {(QW-FW){1'b0}}};
					quo_q <= '0;
				end
			end
			D_ITER: begin
				rem_q <= qbit ? diff[W-1:0] : trial[W-1:0];
				quo_q <= {quo_q[QW-2:0], qbit};
				low_q <= {low_q[QW-2:0], 1'b0};
			end
			D_FIN: begin
				res_q.sat <= quo_q > limit;
				res_q.beta <= neg_q ? (QW'(0) - qclamp) : qclamp;
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

	assign done = done_q;
	assign res = res_q;

endmodule

// ===== src/control_variate_beta_estimator_top.sv =====
// Slope estimator for control variates: beta = cov(x, y) / var(y) over a batch of
// sample_count pairs, signed Q4.12 in, signed Q16.16 out, truncated toward zero and
// saturated. A pair is taken when start is high and busy is low; busy then stays high
// while the one shared 33x33 multiplier forms y*y and x*y, and no new pair is taken
// until busy falls again. The pair that completes a batch keeps busy high longer:
// six multiplier passes build numerator and denominator, a check state tests the
// denominator, then a radix-2 divider produces the 32 quotient bits one per cycle.
// A zero denominator skips the divider; a quotient already past the Q16.16 range
// skips the bit loop. The result is held on beta, zero_denominator and saturated and
// is marked by done, high for exactly one cycle; there is no way to stall it, so the
// receiver must take it in that cycle. A zero denominator returns beta 0 with
// zero_denominator set. The user must write sample_count through wr_en and wr_data
// only while the block is idle; the block does not enforce this. It resets to 1024.
module control_variate_beta_estimator_top #(
	parameter int SAMPLE_WIDTH = cvbe_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [SAMPLE_WIDTH-1:0]        sample_x,
	input  logic signed [SAMPLE_WIDTH-1:0]        sample_y,
	input  logic                                  wr_en,
	input  logic [cvbe_pkg::CNT_W-1:0]            wr_data,
	output logic                                  busy,
	output logic                                  done,
	output logic signed [cvbe_pkg::BETA_W-1:0]    beta,
	output logic                                  zero_denominator,
	output logic                                  saturated
);

	localparam int CNT_W = cvbe_pkg::CNT_W;
	localparam int SUM_W = cvbe_pkg::SUM_W;
	localparam int ACC_W = cvbe_pkg::ACC_W;
	localparam int HALF_W = cvbe_pkg::HALF_W;
	localparam int MUL_W = cvbe_pkg::MUL_W;
	localparam int W = cvbe_pkg::WIDE_W;
	localparam int SUM_EXT = SUM_W - SAMPLE_WIDTH;
	localparam int MUL_EXT = MUL_W - SAMPLE_WIDTH;

	localparam logic [2:0] SMP_YY  = 3'd0;
	localparam logic [2:0] SMP_XY  = 3'd1;
	localparam logic [2:0] SMP_ACC = 3'd2;

	localparam logic [2:0] F_XY_LO = 3'd0;
	localparam logic [2:0] F_XY_HI = 3'd1;
	localparam logic [2:0] F_SXSY  = 3'd2;
	localparam logic [2:0] F_NUM   = 3'd3;
	localparam logic [2:0] F_YY_HI = 3'd4;
	localparam logic [2:0] F_SYSY  = 3'd5;
	localparam logic [2:0] F_DEN   = 3'd6;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SMP  = 5'b00010,
		ST_FORM = 5'b00100,
		ST_CHK  = 5'b01000,
		ST_DIV  = 5'b10000
	} state_t;

	state_t state_q;
	logic [2:0] step_q;
	logic [CNT_W-1:0] sample_count_q;
	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] sum_x_q;
	logic [SUM_W-1:0] sum_y_q;
	logic [ACC_W-1:0] sum_yy_q;
	logic [ACC_W-1:0] sum_xy_q;

	logic signed [SAMPLE_WIDTH-1:0] x_q;
	logic signed [SAMPLE_WIDTH-1:0] y_q;
	logic [W-1:0] acc_q;
	logic [W-1:0] num_q;
	logic [W-1:0] den_q;

	logic done_q;
	logic [cvbe_pkg::BETA_W-1:0] beta_q;
	logic zden_q;
	logic sat_q;

	logic accept;
	logic signed [MUL_W-1:0] mul_a;
	logic signed [MUL_W-1:0] mul_b;
	logic [W-1:0] prod_q;
	logic [W-1:0] prod_hi;
	logic div_start;
	logic div_done;
	cvbe_pkg::div_res_t div_res;

	logic signed [MUL_W-1:0] x_ext;
	logic signed [MUL_W-1:0] y_ext;
	logic signed [MUL_W-1:0] n_ext;
	logic signed [MUL_W-1:0] sx_ext;
	logic signed [MUL_W-1:0] sy_ext;

	assign accept = start && (state_q == ST_IDLE);
	assign div_start = (state_q == ST_CHK) && (den_q != '0);
	assign prod_hi = {prod_q[W-HALF_W-1:0], {HALF_W{1'b0}}};

	assign x_ext = {{MUL_EXT{x_q[SAMPLE_WIDTH-1]}}, x_q};
	assign y_ext = {{MUL_EXT{y_q[SAMPLE_WIDTH-1]}}, y_q};
	assign n_ext = {{(MUL_W-CNT_W){1'b0}}, count_q};
	assign sx_ext = {sum_x_q[SUM_W-1], sum_x_q};
	assign sy_ext = {sum_y_q[SUM_W-1], sum_y_q};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_SMP: begin
				mul_a = (step_q == SMP_YY) ? y_ext : x_ext;
				mul_b = y_ext;
			end
			ST_FORM: begin
				case (step_q)
					F_XY_LO: begin
						mul_a = n_ext;
						mul_b = {{(MUL_W-HALF_W){1'b0}}, sum_xy_q[HALF_W-1:0]};
					end
					F_XY_HI: begin
						mul_a = n_ext;
						mul_b = {{(MUL_W-HALF_W){sum_xy_q[ACC_W-1]}}, sum_xy_q[ACC_W-1:HALF_W]};
					end
					F_SXSY: begin
						mul_a = sx_ext;
						mul_b = sy_ext;
					end
					F_NUM: begin
						mul_a = n_ext;
						mul_b = {{(MUL_W-HALF_W){1'b0}}, sum_yy_q[HALF_W-1:0]};
					end
					F_YY_HI: begin
						mul_a = n_ext;
						mul_b = {{(MUL_W-HALF_W){sum_yy_q[ACC_W-1]}}, sum_yy_q[ACC_W-1:HALF_W]};
					end
					F_SYSY: begin
						mul_a = sy_ext;
						mul_b = sy_ext;
					end
					default: begin
						mul_a = '0;
						mul_b = '0;
					end
				endcase
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	cvbe_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	cvbe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (den_q),
		.done   (div_done),
		.res    (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			sample_count_q <= cvbe_pkg::SAMPLE_COUNT_RST;
			count_q <= '0;
			sum_x_q <= '0;
			sum_y_q <= '0;
			sum_yy_q <= '0;
			sum_xy_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (wr_en) begin
				sample_count_q <= wr_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						count_q <= count_q + 1'b1;
						sum_x_q <= sum_x_q + {{SUM_EXT{sample_x[SAMPLE_WIDTH-1]}}, sample_x};
						sum_y_q <= sum_y_q + {{SUM_EXT{sample_y[SAMPLE_WIDTH-1]}}, sample_y};
						step_q <= SMP_YY;
						state_q <= ST_SMP;
					end
				end
				ST_SMP: begin
					step_q <= step_q + 1'b1;
					if (step_q == SMP_XY) begin
						sum_yy_q <= sum_yy_q + prod_q[ACC_W-1:0];
					end
					if (step_q == SMP_ACC) begin
						sum_xy_q <= sum_xy_q + prod_q[ACC_W-1:0];
						step_q <= F_XY_LO;
						state_q <= (count_q >= sample_count_q) ? ST_FORM : ST_IDLE;
					end
				end
				ST_FORM: begin
					step_q <= step_q + 1'b1;
					if (step_q == F_DEN) begin
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					count_q <= '0;
					sum_x_q <= '0;
					sum_y_q <= '0;
					sum_yy_q <= '0;
					sum_xy_q <= '0;
					if (den_q == '0) begin
						done_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						done_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= sample_x;
			y_q <= sample_y;
		end
		if (state_q == ST_FORM) begin
			case (step_q)
				F_XY_HI: acc_q <= prod_q;
				F_SXSY:  acc_q <= acc_q + prod_hi;
				F_NUM:   num_q <= acc_q - prod_q;
				F_YY_HI: acc_q <= prod_q;
				F_SYSY:  acc_q <= acc_q + prod_hi;
				F_DEN:   den_q <= acc_q - prod_q;
				default: acc_q <= acc_q;
			endcase
		end
		if ((state_q == ST_CHK) && (den_q == '0)) begin
			beta_q <= '0;
			zden_q <= 1'b1;
			sat_q <= 1'b0;
		end else if ((state_q == ST_DIV) && div_done) begin
			beta_q <= div_res.beta;
			zden_q <= 1'b0;
			sat_q <= div_res.sat;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign beta = beta_q;
	assign zero_denominator = zden_q;
	assign saturated = sat_q;

endmodule

// ===== src/cvbe_checker.sv =====
module cvbe_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             start,
	input logic                             busy,
	input logic                             done,
	input logic [cvbe_pkg::BETA_W-1:0]      beta,
	input logic                             zero_denominator,
	input logic                             saturated
);

	a_beat_follows_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result beat without prior work");

	a_single_beat: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result beats back to back");

	a_accept_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted pair did not raise busy");

	a_zero_den_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done && zero_denominator) |-> (beta == '0 && !saturated))
		else $error("zero denominator result not cleared");

	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && saturated) |->
			(beta == cvbe_pkg::BETA_POS_LIMIT || beta == cvbe_pkg::BETA_NEG_LIMIT))
		else $error("saturated beta not at a limit");

endmodule

bind control_variate_beta_estimator_top cvbe_checker u_cvbe_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.start            (start),
	.busy             (busy),
	.done             (done),
	.beta             (beta),
	.zero_denominator (zero_denominator),
	.saturated        (saturated)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

	localparam int SW = cvbe_pkg::SAMPLE_WIDTH_DEF;
	localparam int CNT_W = cvbe_pkg::CNT_W;
	localparam int SUM_W = cvbe_pkg::SUM_W;
	localparam int ACC_W = cvbe_pkg::ACC_W;
	localparam int WIDE_W = cvbe_pkg::WIDE_W;
	localparam int BETA_W = cvbe_pkg::BETA_W;
	localparam int FRAC_W = cvbe_pkg::FRAC_W;
	localparam int SETTLE = 8;
	localparam int DRAIN = 64;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int N_DIRECTED = 31;
	localparam int N_PHASES = 12;
	localparam int PHASE_PAIRS = 34;
	localparam int MODE_FLAT_Y = 4;
	localparam int MODE_TIGHT_Y = 5;

	typedef enum logic [1:0] {
		ROW_PAIR,
		ROW_CHECKED,
		ROW_COUNT
	} row_kind_t;

	typedef struct packed {
		logic [BETA_W-1:0] beta;
		logic              zero_den;
		logic              sat;
	} estimate_t;

	typedef struct packed {
		row_kind_t        kind;
		logic [CNT_W-1:0] count;
		logic [SW-1:0]    x;
		logic [SW-1:0]    y;
		estimate_t        lit;
	} stim_row_t;

	localparam estimate_t NO_EST = '0;
	localparam estimate_t FLAT_Y = '{'0, 1'b1, 1'b0};

	// N=2 batches give cov/var = (x1-x2)/(y1-y2)
	stim_row_t directed [N_DIRECTED] = '{
		'{ROW_PAIR,    16'd0,     16'h7fff, 16'h7fff, NO_EST},
		'{ROW_PAIR,    16'd0,     16'h8000, 16'h8000, NO_EST},
		'{ROW_COUNT,   16'd2,     16'h0000, 16'h0000, NO_EST},
		'{ROW_PAIR,    16'd0,     16'h0000, 16'h0000, NO_EST},
		'{ROW_COUNT,   16'd1,     16'h0000, 16'h0000, NO_EST},
		'{ROW_CHECKED, 16'd0,     16'h7fff, 16'h8000, FLAT_Y},
		'{ROW_COUNT,   16'd0,     16'h0000, 16'h0000, NO_EST},
		'{ROW_CHECKED, 16'd0,     16'h8000, 16'h7fff, FLAT_Y},
		'{ROW_COUNT,   16'd2,     16'h0000, 16'h0000, NO_EST},
		'{ROW_PAIR,    16'd0,     16'h0001, 16'h0005, NO_EST},
		'{ROW_CHECKED, 16'd0,     16'h0003, 16'h0005, FLAT_Y},
		'{ROW_PAIR,    16'd0,     16'h1000, 16'h1000, NO_EST},
		'{ROW_CHECKED, 16'd0,     16'h2000, 16'h2000, '{32'h0001_0000, 1'b0, 1'b0}},
		'{ROW_PAIR,    16'd0,     16'hf000, 16'h1000, NO_EST},
		'{ROW_CHECKED, 16'd0,     16'he000, 16'h2000, '{32'hffff_0000, 1'b0, 1'b0}},
		'{ROW_PAIR,    16'd0,     16'h7fff, 16'h0001, NO_EST},
		'{ROW_CHECKED, 16'd0,     16'h8000, 16'h0000, '{32'h7fff_ffff, 1'b0, 1'b1}},
		'{ROW_PAIR,    16'd0,     16'h8000, 16'h0001, NO_EST},
		'{ROW_CHECKED, 16'd0,     16'h7fff, 16'h0000, '{32'h8000_0000, 1'b0, 1'b1}},
		'{ROW_PAIR,    16'd0,     16'h8000, 16'h0001, NO_EST},
		'{ROW_CHECKED, 16'd0,     16'h0000, 16'h0000, '{32'h8000_0000, 1'b0, 1'b0}},
		'{ROW_PAIR,    16'd0,     16'h0001, 16'h0003, NO_EST},
		'{ROW_CHECKED, 16'd0,     16'h0000, 16'h0000, '{32'h0000_5555, 1'b0, 1'b0}},
		'{ROW_PAIR,    16'd0,     16'h0000, 16'h0003, NO_EST},
		'{ROW_CHECKED, 16'd0,     16'h0001, 16'h0000, '{32'hffff_aaab, 1'b0, 1'b0}},
		'{ROW_COUNT,   16'hffff,  16'h0000, 16'h0000, NO_EST},
		'{ROW_PAIR,    16'd0,     16'h1234, 16'hedcb, NO_EST},
		'{ROW_PAIR,    16'd0,     16'h8001, 16'h7ffe, NO_EST},
		'{ROW_PAIR,    16'd0,     16'h0fff, 16'ha5a5, NO_EST},
		'{ROW_COUNT,   16'd2,     16'h0000, 16'h0000, NO_EST},
		'{ROW_PAIR,    16'd0,     16'h5a5a, 16'h0f0f, NO_EST}
	};

	logic [CNT_W-1:0] phase_counts [N_PHASES] = '{
		16'hffff, 16'd2, 16'd0, 16'd5, 16'd1, 16'd3,
		16'd16, 16'd2, 16'd9, 16'd40, 16'd4, 16'd12
	};

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic signed [SW-1:0]     sample_x;
	logic signed [SW-1:0]     sample_y;
	logic                     wr_en;
	logic [CNT_W-1:0]         wr_data;
	logic                     busy;
	logic                     done;
	logic signed [BETA_W-1:0] beta;
	logic                     zero_denominator;
	logic                     saturated;

	logic [CNT_W-1:0] batch_len = cvbe_pkg::SAMPLE_COUNT_RST;
	logic [CNT_W-1:0] n_acc = '0;
	logic [SUM_W-1:0] sx_acc = '0;
	logic [SUM_W-1:0] sy_acc = '0;
	logic [ACC_W-1:0] syy_acc = '0;
	logic [ACC_W-1:0] sxy_acc = '0;

	estimate_t pending_betas[$];
	int mismatches = 0;
	int beats = 0;
	int betas = 0;
	int settings = 0;
	int zd_seen = 0;
	int sat_seen = 0;
	int quiet = 0;

	control_variate_beta_estimator_top #(
		.SAMPLE_WIDTH(SW)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.sample_x(sample_x),
		.sample_y(sample_y),
		.wr_en(wr_en),
		.wr_data(wr_data),
		.busy(busy),
		.done(done),
		.beta(beta),
		.zero_denominator(zero_denominator),
		.saturated(saturated)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic bit predict_pair(input logic [SW-1:0] x, input logic [SW-1:0] y,
		output estimate_t est);
		logic [WIDE_W-1:0] xw, yw, prod, n, sx, sy, syy, sxy, num, den;
		logic [WIDE_W-1:0] mn, md, quo, rem, lim, q;
		logic carry;
		logic neg;
		xw = {{(WIDE_W-SW){x[SW-1]}}, x};
		yw = {{(WIDE_W-SW){y[SW-1]}}, y};
		n_acc = n_acc + 1'b1;
		sx_acc = sx_acc + xw[SUM_W-1:0];
		sy_acc = sy_acc + yw[SUM_W-1:0];
		prod = yw * yw;
		syy_acc = syy_acc + prod[ACC_W-1:0];
		prod = xw * yw;
		sxy_acc = sxy_acc + prod[ACC_W-1:0];
		est = '0;
		if (n_acc < batch_len)
			return 1'b0;
		n = {{(WIDE_W-CNT_W){1'b0}}, n_acc};
		sx = {{(WIDE_W-SUM_W){sx_acc[SUM_W-1]}}, sx_acc};
		sy = {{(WIDE_W-SUM_W){sy_acc[SUM_W-1]}}, sy_acc};
		syy = {{(WIDE_W-ACC_W){syy_acc[ACC_W-1]}}, syy_acc};
		sxy = {{(WIDE_W-ACC_W){sxy_acc[ACC_W-1]}}, sxy_acc};
		num = n * sxy - sx * sy;
		den = n * syy - sy * sy;
		if (den == '0) begin
			est.zero_den = 1'b1;
		end else begin
			neg = num[WIDE_W-1] ^ den[WIDE_W-1];
			mn = num[WIDE_W-1] ? -num : num;
			md = den[WIDE_W-1] ? -den : den;
			quo = mn / md;
			rem = mn % md;
			lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
			if (quo >= 64'h1_0000) begin
				q = lim + 1'b1;
			end else begin
				q = quo;
				for (int i = 0; i < FRAC_W; i++) begin
					carry = rem[WIDE_W-1];
					rem = rem << 1;
					q = q << 1;
					if (carry || rem >= md) begin
						rem = rem - md;
						q[0] = 1'b1;
					end
				end
			end
			if (q > lim) begin
				q = lim;
				est.sat = 1'b1;
			end
			mn = -q;
			est.beta = neg ? mn[BETA_W-1:0] : q[BETA_W-1:0];
		end
		n_acc = '0;
		sx_acc = '0;
		sy_acc = '0;
		syy_acc = '0;
		sxy_acc = '0;
		return 1'b1;
	endfunction

	task automatic flag_mismatch(input string what, input logic [BETA_W-1:0] got,
		input logic [BETA_W-1:0] want);
		$display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic drive_pair(input logic [SW-1:0] x, input logic [SW-1:0] y,
		input bit typed, input estimate_t lit);
		estimate_t est;
		start <= 1'b1;
		sample_x <= x;
		sample_y <= y;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		beats++;
		if (predict_pair(x, y, est))
			pending_betas.push_back(typed ? lit : est);
	endtask

	task automatic pause(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic write_count(input logic [CNT_W-1:0] value);
		start <= 1'b0;
		while (pending_betas.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		while (busy)
			@(posedge clk);
		wr_en <= 1'b1;
		wr_data <= value;
		@(posedge clk);
		wr_en <= 1'b0;
		batch_len = value;
		settings++;
	endtask

	always @(posedge clk) begin
		estimate_t want;
		if (arst_n && done) begin
			if (pending_betas.size() == 0) begin
				flag_mismatch("unexpected beta", beta, '0);
			end else begin
				want = pending_betas.pop_front();
				betas++;
				if (want.zero_den)
					zd_seen++;
				if (want.sat)
					sat_seen++;
				if (beta !== want.beta)
					flag_mismatch("beta", beta, want.beta);
				if (zero_denominator !== want.zero_den)
					flag_mismatch("zero_denominator", BETA_W'(zero_denominator),
						BETA_W'(want.zero_den));
				if (saturated !== want.sat)
					flag_mismatch("saturated", BETA_W'(saturated), BETA_W'(want.sat));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("control_variate_beta_estimator_top verification failed");
				$finish;
			end
		end
	end

	initial begin
		int pm, r, burst;
		logic [SW-1:0] x, y, ybase;
		arst_n <= 1'b0;
		start <= 1'b0;
		sample_x <= '0;
		sample_y <= '0;
		wr_en <= 1'b0;
		wr_data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			case (directed[i].kind)
				ROW_COUNT:   write_count(directed[i].count);
				ROW_PAIR:    drive_pair(directed[i].x, directed[i].y, 1'b0, NO_EST);
				ROW_CHECKED: drive_pair(directed[i].x, directed[i].y, 1'b1, directed[i].lit);
				default: ;
			endcase
		end

		for (int p = 0; p < N_PHASES; p++) begin
			write_count(phase_counts[p]);
			// some phases hold y flat, others keep its spread tiny so the slope can saturate
			pm = $urandom_range(0, MODE_TIGHT_Y);
			ybase = SW'($urandom);
			burst = 0;
			repeat (PHASE_PAIRS + $urandom_range(0, 4)) begin
				if (burst == 0) begin
					if ($urandom_range(0, 3) != 0)
						pause($urandom_range(1, 7));
					burst = $urandom_range(1, 24);
				end
				burst--;
				x = SW'($urandom);
				y = SW'($urandom);
				r = $urandom_range(0, 9);
				if (r < 3)
					y = x + SW'($urandom_range(0, 63)) - SW'(32);
				else if (r == 3)
					x = {1'b0, {(SW-1){1'b1}}};
				else if (r == 4)
					x = {1'b1, {(SW-1){1'b0}}};
				else if (r == 5)
					y = {1'b1, {(SW-1){1'b0}}};
				if (pm == MODE_FLAT_Y)
					y = ybase;
				else if (pm == MODE_TIGHT_Y)
					y = SW'($urandom_range(0, 2));
				drive_pair(x, y, 1'b0, NO_EST);
			end
		end

		start <= 1'b0;
		while (pending_betas.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		$display("ran %0d sample beats and checked %0d beta results over %0d count settings",
			beats, betas, settings);
		$display("of those results %0d had a zero denominator and %0d saturated",
			zd_seen, sat_seen);
		if (mismatches == 0)
			$display("control_variate_beta_estimator_top verification clean");
		else
			$display("control_variate_beta_estimator_top verification failed");
		$finish;
	end

endmodule
